/* hdl/rndm_pkg.sv */
// Package with shared constants, types and state codes of the ranked donor match unit.
`default_nettype none
package rndm_pkg;

  localparam int MAX_DONORS = 1024;
  localparam int MAX_RANK   = 64;

  localparam int VAL_W   = 32;
  localparam int EXCL_W  = 16;
  localparam int RIN_W   = 7;
  localparam int POS_W   = 11;
  localparam int ADDR_W  = (MAX_DONORS > 1) ? $clog2(MAX_DONORS) : 1;
  localparam int CNT_W   = $clog2(MAX_DONORS + 1);
  localparam int RANK_W  = $clog2(MAX_RANK + 1);
  localparam int IDX_W   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int SEL_A   = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam int SEL_W   = (SEL_A > RIN_W) ? SEL_A : RIN_W;
  localparam int DIST_W  = VAL_W + 1;
  // Distance, side flag (left is one), then a tie break on load order.
  localparam int KEY_W   = DIST_W + 1 + ADDR_W;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] outcome;
  } donor_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] pos;
  } entry_t;

  typedef struct packed {
    logic             clear;
    logic             en;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] pos;
  } ins_t;

endpackage
`default_nettype wire

/* hdl/rndm_ifs.sv */
// Valid/ready channel interfaces for query input items and match results.
`default_nettype none
interface rndm_in_if;
  import rndm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic signed [VAL_W-1:0]  value;
  logic signed [VAL_W-1:0]  donor_outcome;
  logic signed [EXCL_W-1:0] exclude_outcome;
  logic [RIN_W-1:0]         rank;
  modport source (output valid, action, value, donor_outcome, exclude_outcome, rank,
                  input ready);
  modport sink (input valid, action, value, donor_outcome, exclude_outcome, rank,
                output ready);
endinterface

interface rndm_out_if;
  import rndm_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] donor_position;
  logic             found;
  modport source (output valid, donor_position, found, input ready);
  modport sink (input valid, donor_position, found, output ready);
endinterface
`default_nettype wire

/* hdl/rndm_donor_ram.sv */
// Donor store in load order: one write port and one registered read port.
`default_nettype none
module rndm_donor_ram
  import rndm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire donor_t            wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output donor_t                 rdata
);

  donor_t mem [MAX_DONORS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/rndm_rank_cell.sv */
// One cell of the sorted candidate row: keeps its key or takes the new or the left one.
`default_nettype none
module rndm_rank_cell
  import rndm_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire ins_t   ins,
  input  wire entry_t prev,
  input  wire logic   prev_take,
  output entry_t      cur,
  output logic        take
);

  // A cell gives way when it is empty or its key is larger than the new key.
  assign take = !cur.valid || (ins.key < cur.key);

  always_ff @(posedge clk) begin
    if (rst || ins.clear) begin
      cur.valid <= 1'b0;
    end else if (ins.en && take) begin
      if (prev_take) begin
        cur <= prev;
      end else begin
        cur <= '{valid: 1'b1, key: ins.key, pos: ins.pos};
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/rndm_rank_chain.sv */
// Row of rank cells holding the smallest keys in ascending order, with a read select.
`default_nettype none
module rndm_rank_chain
  import rndm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ins_t             ins,
  input  wire logic [IDX_W-1:0] sel,
  output entry_t                sel_entry
);

  entry_t cells [MAX_RANK];
  logic   takes [MAX_RANK];

  genvar g;
  generate
    for (g = 0; g < MAX_RANK; g++) begin : g_cell
      if (g == 0) begin : g_head
        rndm_rank_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .ins       (ins),
          .prev      ('0),
          .prev_take (1'b0),
          .cur       (cells[g]),
          .take      (takes[g])
        );
      end else begin : g_body
        rndm_rank_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .ins       (ins),
          .prev      (cells[g-1]),
          .prev_take (takes[g-1]),
          .cur       (cells[g]),
          .take      (takes[g])
        );
      end
    end
  endgenerate

  assign sel_entry = cells[sel];

endmodule
`default_nettype wire

/* hdl/ranked_nearest_donor_match_unit.sv */
// Top level of the ranked nearest donor match unit.
//
//  channel | dir | payload                                              | role
//  --------+-----+------------------------------------------------------+------------------
//  in_ch   | in  | action, value, donor_outcome, exclude_outcome, rank  | clear, load, query
//  out_ch  | out | donor_position, found                                | one per query
//
// A query reads every loaded donor once through the single read port of the donor memory
// and streams the usable ones into the rank cell row; an empty store goes straight to the
// result. Synchronous active-high reset empties the store and the output register; memory
// contents are not cleared. A result waits in the output register while the next item is
// already taken, and a query holds in its final state only while an earlier result still
// waits for its transfer.
`default_nettype none
module ranked_nearest_donor_match_unit
  import rndm_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  rndm_in_if.sink    in_ch,
  rndm_out_if.source out_ch
);

  state_t state, state_next;

  logic [CNT_W-1:0]         donor_count;
  logic [ADDR_W-1:0]        scan_addr;
  logic [ADDR_W-1:0]        data_addr;
  logic                     rd_vld;
  logic [CNT_W-1:0]         nuse;
  logic signed [VAL_W-1:0]  target;
  logic signed [EXCL_W-1:0] excl;
  logic [SEL_W-1:0]         rank_q;
  logic                     out_valid;
  logic [POS_W-1:0]         out_pos;
  logic                     out_found;

  logic             accept;
  logic             is_query;
  logic             load_we;
  logic             scan_last;
  logic             result_load;
  logic [SEL_W-1:0] rank_in;
  logic [SEL_W-1:0] rank_clamped;
  donor_t           rd_data;
  logic             usable;
  logic [DIST_W-1:0] diff;
  logic             left;
  logic [DIST_W-1:0] distance;
  ins_t             ins;
  logic [SEL_W-1:0] sel_cnt;
  logic [IDX_W-1:0] sel_idx;
  entry_t           sel_entry;

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_query    = accept && (in_ch.action == ACT_QUERY);
  assign load_we     = accept && (in_ch.action == ACT_LOAD) &&
                       (donor_count < CNT_W'(MAX_DONORS));
  assign scan_last   = ({1'b0, scan_addr} == (donor_count - CNT_W'(1)));
  assign result_load = (state == ST_RESULT) && (!out_valid || out_ch.ready);

  // Rank 0 counts as 1 and ranks above the row length as the row length.
  assign rank_in = SEL_W'(in_ch.rank);
  always_comb begin
    rank_clamped = rank_in;
    if (rank_in == '0) begin
      rank_clamped = SEL_W'(1);
    end else if (rank_in > SEL_W'(MAX_RANK)) begin
      rank_clamped = SEL_W'(MAX_RANK);
    end
  end

  rndm_donor_ram u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (donor_count[ADDR_W-1:0]),
    .wdata ('{value: in_ch.value, outcome: in_ch.donor_outcome}),
    .re    (state == ST_SCAN),
    .raddr (scan_addr),
    .rdata (rd_data)
  );

  // Each streamed donor gets a key that orders it exactly as the outward walk would:
  // smaller distance first, the right side first on equal distance, and among equal
  // values the later load first on the left and the earlier load first on the right.
  assign usable   = (rd_data.outcome != {excl, 16'b0});
  assign diff     = {rd_data.value[VAL_W-1], rd_data.value} - {target[VAL_W-1], target};
  assign left     = diff[DIST_W-1];
  assign distance = left ? (~diff + DIST_W'(1)) : diff;

  assign ins.clear = is_query;
  assign ins.en    = rd_vld && usable;
  assign ins.key   = {distance, left, left ? ~data_addr : data_addr};
  assign ins.pos   = CNT_W'(data_addr) + CNT_W'(1);

  // The answer is the candidate at the clamped rank, or the last usable one.
  assign sel_cnt = (rank_q < SEL_W'(nuse)) ? rank_q : SEL_W'(nuse);
  assign sel_idx = IDX_W'(sel_cnt - SEL_W'(1));

  rndm_rank_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .ins       (ins),
    .sel       (sel_idx),
    .sel_entry (sel_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (is_query) begin
          state_next = (donor_count == '0) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (result_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      donor_count <= '0;
      rd_vld      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SCAN);
      if (accept && (in_ch.action == ACT_CLEAR)) begin
        donor_count <= '0;
      end else if (load_we) begin
        donor_count <= donor_count + CNT_W'(1);
      end
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_addr <= scan_addr;
    if (is_query) begin
      target    <= in_ch.value;
      excl      <= in_ch.exclude_outcome;
      rank_q    <= rank_clamped;
      scan_addr <= '0;
      nuse      <= '0;
    end else begin
      if (state == ST_SCAN) begin
        scan_addr <= scan_addr + ADDR_W'(1);
      end
      if (ins.en) begin
        nuse <= nuse + CNT_W'(1);
      end
    end
    if (result_load) begin
      out_found <= (nuse != '0);
      out_pos   <= (nuse != '0) ? POS_W'(sel_entry.pos) : '0;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.donor_position = out_pos;
  assign out_ch.found          = out_found;

`ifndef ASSERT_OFF
  a_nuse_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_DRAIN) |-> (nuse <= donor_count))
    else $error("usable donor count exceeds stored donor count");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> (out_pos == '0))
    else $error("position reported without a usable donor");

  a_empty_query: assert property (@(posedge clk) disable iff (rst)
    (is_query && donor_count == '0) |=> (state == ST_RESULT))
    else $error("query on an empty store did not go straight to the result");

  a_selected_valid: assert property (@(posedge clk) disable iff (rst)
    (result_load && nuse != '0) |-> sel_entry.valid)
    else $error("selected rank cell holds no candidate");
`endif

endmodule
`default_nettype wire
